[rtl/disjoint_interval_set_defines.svh]
// Assertion macros for the disjoint interval set.
// Depends on nothing; included by the top level only.
`ifndef DISJOINT_INTERVAL_SET_DEFINES_SVH
`define DISJOINT_INTERVAL_SET_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dis_pkg.sv]
// Shared types, constants and helpers for the disjoint interval set.
// Depends on nothing; used by dis_cell and disjoint_interval_set.
`default_nettype none

package dis_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int VALUE_BITS    = 16;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef struct packed {
        t_val lo;
        t_val hi;
    } t_ival;

    typedef struct packed {
        logic        cmd;
        logic [15:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic        last;
        logic [4:0]  interval_count;
    } t_out;

    typedef enum logic [2:0] {
        STS_NEW     = 3'd0,
        STS_GROW    = 3'd1,
        STS_COVERED = 3'd2,
        STS_FULL    = 3'd3,
        STS_ENTRY   = 3'd4,
        STS_EMPTY   = 3'd5
    } t_status;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ADD,
        MODE_READ
    } t_mode;

    typedef enum logic [2:0] {
        K_NONE,
        K_GROW_PRED,
        K_GROW_SUCC,
        K_JOIN,
        K_NEW
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        t_mode mode;
        t_kind kind;
    } t_bcast;

    // Per-cell match flags returned to the controller.
    typedef struct packed {
        logic pred;
        logic succ;
        logic covered;
        logic grow_pred;
        logic grow_succ;
    } t_cell_flags;

    function automatic t_val val_from_field(input logic [15:0] f);
        logic [VALUE_BITS+15:0] w;
        w = {{VALUE_BITS{1'b0}}, f};
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [15:0] val_to_field(input t_val v);
        logic [VALUE_BITS+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    function automatic logic [4:0] cnt_to_field(input t_cnt c);
        logic [CNT_W+4:0] w;
        w = {5'd0, c};
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

[rtl/dis_cell.sv]
// One cell of the interval chain: holds a single interval and shifts with
// its neighbours. Depends on dis_pkg.
`default_nettype none

module dis_cell import dis_pkg::*; (
    input  wire logic        i_clk,
    input  wire t_bcast      i_bc,
    input  wire t_val        i_v,
    input  wire logic        i_occ,
    input  wire logic        i_tail,
    input  wire logic        i_left_le,
    input  wire logic        i_right_le,
    input  wire t_ival       i_left,
    input  wire t_ival       i_right,
    input  wire t_ival       i_head,
    output logic             o_le,
    output t_ival            o_ival,
    output t_cell_flags      o_flags
);

    t_ival r_ival;
    t_ival n_ival;
    logic  le;
    logic  ge;
    logic  ins_pos;
    logic  is_pred;
    logic  is_succ;

    // le: occupied and starting at or below the value; these form a prefix.
    assign le      = i_occ && (r_ival.lo <= i_v);
    assign ge      = !le;
    assign ins_pos = ge && i_left_le;
    assign is_pred = le && !i_right_le;
    assign is_succ = i_occ && ins_pos;

    always_comb begin
        o_flags.pred      = is_pred;
        o_flags.succ      = is_succ;
        o_flags.covered   = is_pred && (i_v <= r_ival.hi);
        o_flags.grow_pred = is_pred && (({1'b0, r_ival.hi} + 1'b1) == {1'b0, i_v});
        o_flags.grow_succ = is_succ && (({1'b0, i_v} + 1'b1) == {1'b0, r_ival.lo});
    end

    always_comb begin
        n_ival = r_ival;
        case (i_bc.mode)
            MODE_ADD: begin
                case (i_bc.kind)
                    K_GROW_PRED: begin
                        if (is_pred) n_ival.hi = i_v;
                    end
                    K_GROW_SUCC: begin
                        if (is_succ) n_ival.lo = i_v;
                    end
                    K_JOIN: begin
                        // absorb the successor, close the gap above it
                        if (is_pred) n_ival.hi = i_right.hi;
                        else if (i_occ && ge) n_ival = i_right;
                    end
                    K_NEW: begin
                        // open a slot, push everything above it one cell up
                        if (ins_pos) n_ival = '{lo: i_v, hi: i_v};
                        else if (ge) n_ival = i_left;
                    end
                    default: n_ival = r_ival;
                endcase
            end
            MODE_READ: begin
                n_ival = i_tail ? i_head : i_right;
            end
            default: n_ival = r_ival;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ival <= n_ival;
    end

    assign o_le   = le;
    assign o_ival = r_ival;

endmodule

`default_nettype wire

[rtl/disjoint_interval_set.sv]
// Top level of the disjoint interval set: cell chain, controller and output
// register. Depends on dis_pkg, dis_cell and disjoint_interval_set_defines.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   input    | i_valid / o_stall  | i_in  (cmd, value)
//   output   | o_valid / i_stall  | o_out (status, range_start, range_end,
//            |                    |        last, interval_count)
//
// In an add transaction all cells compare at once and the chain shifts on
// insert or join, so adds can follow back to back.
// A read-out transaction emits one entry per interval held:
// the chain rotates through its occupied cells and cell 0 feeds the output.
// Reset (synchronous, active low) empties the set and stalls the input.
// Downstream stall holds the output register and, through o_stall, the input.
`default_nettype none

`include "disjoint_interval_set_defines.svh"

module disjoint_interval_set import dis_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_in,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_out
);

    // Controller state
    t_state r_state;
    t_state n_state;
    t_cnt   r_count;
    t_cnt   n_count;
    t_cnt   r_rd_idx;
    t_cnt   n_rd_idx;
    logic   r_out_valid;
    logic   n_out_valid;
    t_out   r_out;
    t_out   n_out;

    logic   can_adv;
    logic   in_acc;
    logic   add_acc;
    logic   read_acc;
    logic   rd_step;
    logic   rd_last;
    logic   busy;
    t_val   v;

    t_bcast bc;

    // Chain wiring
    logic        c_le    [MAX_INTERVALS];
    t_ival       c_ival  [MAX_INTERVALS];
    t_cell_flags c_flags [MAX_INTERVALS];

    // Reduced match results
    logic  any_cov;
    logic  any_gp;
    logic  any_gs;
    t_val  pred_lo;
    t_val  pred_hi;
    t_val  succ_hi;

    assign v        = val_from_field(i_in.value);
    assign can_adv  = !r_out_valid || !i_stall;
    assign o_stall  = !i_rst_n || busy || !can_adv;
    assign in_acc   = i_valid && !o_stall;
    assign add_acc  = in_acc && (i_in.cmd == CMD_ADD);
    assign read_acc = in_acc && (i_in.cmd == CMD_READ);
    assign rd_last  = (CNT_W'(r_rd_idx + 1'b1) == r_count);

    // ---------------------------------------------------------------------
    // Read-out sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (read_acc && (r_count != '0)) n_state = ST_READ;
            end
            ST_READ: begin
                if (rd_step && rd_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Read-out sequencer: outputs
    always_comb begin
        busy    = 1'b0;
        rd_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                rd_step = 1'b0;
            end
            ST_READ: begin
                // hold the input while entries stream out
                busy    = 1'b1;
                rd_step = can_adv;
            end
            default: begin
                busy    = 1'b0;
                rd_step = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_INTERVALS; gi++) begin : g_cell
        logic  left_le;
        logic  right_le;
        t_ival right_ival;
        t_ival left_ival;

        if (gi == 0) begin : g_first
            assign left_le   = 1'b1;
            assign left_ival = '0;
        end else begin : g_mid_left
            assign left_le   = c_le[gi-1];
            assign left_ival = c_ival[gi-1];
        end

        if (gi == MAX_INTERVALS - 1) begin : g_last
            assign right_le   = 1'b0;
            assign right_ival = '0;
        end else begin : g_mid_right
            assign right_le   = c_le[gi+1];
            assign right_ival = c_ival[gi+1];
        end

        dis_cell u_cell (
            .i_clk      (i_clk),
            .i_bc       (bc),
            .i_v        (v),
            .i_occ      (CNT_W'(gi) < r_count),
            .i_tail     (CNT_W'(gi + 1) == r_count),
            .i_left_le  (left_le),
            .i_right_le (right_le),
            .i_left     (left_ival),
            .i_right    (right_ival),
            .i_head     (c_ival[0]),
            .o_le       (c_le[gi]),
            .o_ival     (c_ival[gi]),
            .o_flags    (c_flags[gi])
        );
    end

    // Gather the one-hot predecessor and successor matches.
    always_comb begin
        any_cov = 1'b0;
        any_gp  = 1'b0;
        any_gs  = 1'b0;
        pred_lo = '0;
        pred_hi = '0;
        succ_hi = '0;
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            any_cov = any_cov | c_flags[i].covered;
            any_gp  = any_gp  | c_flags[i].grow_pred;
            any_gs  = any_gs  | c_flags[i].grow_succ;
            pred_lo = pred_lo | (c_flags[i].pred ? c_ival[i].lo : '0);
            pred_hi = pred_hi | (c_flags[i].pred ? c_ival[i].hi : '0);
            succ_hi = succ_hi | (c_flags[i].succ ? c_ival[i].hi : '0);
        end
    end

    // Decide the add action and broadcast it down the chain.
    always_comb begin
        bc.kind = K_NONE;
        bc.mode = MODE_IDLE;
        if (any_cov)                            bc.kind = K_NONE;
        else if (any_gp && any_gs)              bc.kind = K_JOIN;
        else if (any_gp)                        bc.kind = K_GROW_PRED;
        else if (any_gs)                        bc.kind = K_GROW_SUCC;
        else if (r_count < CNT_W'(MAX_INTERVALS)) bc.kind = K_NEW;
        if (add_acc)      bc.mode = MODE_ADD;
        else if (rd_step) bc.mode = MODE_READ;
    end

    // ---------------------------------------------------------------------
    // Result formation and bookkeeping
    // ---------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        if (add_acc) begin
            n_out_valid      = 1'b1;
            n_out.last       = 1'b1;
            n_out.status     = STS_GROW;
            n_out.range_start = '0;
            n_out.range_end   = '0;
            case (bc.kind)
                K_JOIN: begin
                    n_count           = CNT_W'(r_count - 1'b1);
                    n_out.range_start = val_to_field(pred_lo);
                    n_out.range_end   = val_to_field(succ_hi);
                end
                K_GROW_PRED: begin
                    n_out.range_start = val_to_field(pred_lo);
                    n_out.range_end   = val_to_field(v);
                end
                K_GROW_SUCC: begin
                    n_out.range_start = val_to_field(v);
                    n_out.range_end   = val_to_field(succ_hi);
                end
                K_NEW: begin
                    n_count           = CNT_W'(r_count + 1'b1);
                    n_out.status      = STS_NEW;
                    n_out.range_start = val_to_field(v);
                    n_out.range_end   = val_to_field(v);
                end
                default: begin
                    // covered, or dropped because the chain is full
                    if (any_cov) begin
                        n_out.status      = STS_COVERED;
                        n_out.range_start = val_to_field(pred_lo);
                        n_out.range_end   = val_to_field(pred_hi);
                    end else begin
                        n_out.status = STS_FULL;
                    end
                end
            endcase
            n_out.interval_count = cnt_to_field(n_count);
        end else if (read_acc) begin
            n_rd_idx = '0;
            if (r_count == '0) begin
                n_out_valid          = 1'b1;
                n_out.status         = STS_EMPTY;
                n_out.range_start    = '0;
                n_out.range_end      = '0;
                n_out.last           = 1'b1;
                n_out.interval_count = cnt_to_field(r_count);
            end
        end else if (rd_step) begin
            // emit the head cell, then advance the rotation
            n_out_valid          = 1'b1;
            n_out.status         = STS_ENTRY;
            n_out.range_start    = val_to_field(c_ival[0].lo);
            n_out.range_end      = val_to_field(c_ival[0].hi);
            n_out.last           = rd_last;
            n_out.interval_count = cnt_to_field(r_count);
            n_rd_idx             = CNT_W'(r_rd_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `DIS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_INTERVALS), "interval count beyond capacity")
    `DIS_ASSERT_NEXT(a_count_stable, i_clk, i_rst_n, !add_acc,
        $stable(r_count), "interval count changed without an add")
    `DIS_ASSERT_NEXT(a_add_result, i_clk, i_rst_n, add_acc,
        o_valid && o_out.last, "add transaction produced no final result")
    `DIS_ASSERT_NEXT(a_read_start, i_clk, i_rst_n, read_acc && (r_count != '0),
        r_state == ST_READ, "read-out did not start")

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for disjoint_interval_set: a directed table, then random add and
// read-out transactions, checked against typed results or an interval-set model in the bench.
// Depends on dis_pkg and the disjoint_interval_set RTL; needs nothing else.
module testbench;
    import dis_pkg::*;

    localparam int unsigned RANDOM_TXNS     = 224;
    localparam int unsigned QUIET_TXNS      = 40;      // final stretch with no idling
    localparam int unsigned HOLD_OFF_AT     = 60;      // random item that triggers the long stall
    localparam int unsigned DRAIN_PAUSE_AT  = 120;     // random item that waits for a full drain
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_in    = '0;
    logic o_stall;
    logic o_valid;
    t_out o_out;

    disjoint_interval_set dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // Period of two time units.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Interval-set model: sorted, disjoint, closed spans.
    // Only the first span_count entries are meaningful.
    // ------------------------------------------------------------------
    logic [15:0] span_lo [MAX_INTERVALS];
    logic [15:0] span_hi [MAX_INTERVALS];
    int unsigned span_count = 0;

    t_out expected_q [$];   // results still owed by the block, oldest first
    t_out fresh_res  [$];   // results of the transaction just modelled
    int unsigned mismatches = 0;

    bit hold_off_now = 1'b0;   // ask the receiver for one long stall
    bit quiet        = 1'b0;   // final stretch: no idling on either side

    function automatic t_out make_res(input t_status st, input logic [15:0] lo,
                                      input logic [15:0] hi, input logic fin);
        t_out r;
        r.status         = st;
        r.range_start    = lo;
        r.range_end      = hi;
        r.last           = fin;
        r.interval_count = 5'(span_count);
        return r;
    endfunction

    // Apply one accepted transaction to the model and collect its results.
    function automatic void apply_to_set(input t_in it);
        logic [15:0] v;
        int unsigned nxt, prv, k;
        bit          has_prv, has_nxt, grow_up, grow_down;
        fresh_res.delete();
        if (it.cmd == CMD_READ) begin
            if (span_count == 0) begin
                fresh_res.push_back(make_res(STS_EMPTY, 16'h0000, 16'h0000, 1'b1));
            end else begin
                for (k = 0; k < span_count; k++)
                    fresh_res.push_back(make_res(STS_ENTRY, span_lo[k], span_hi[k],
                                                 k + 1 == span_count));
            end
            return;
        end
        v = it.value;
        // Find the first span that starts above the value.
        nxt = 0;
        while (nxt < span_count && span_lo[nxt] <= v)
            nxt++;
        has_prv = nxt > 0;
        has_nxt = nxt < span_count;
        prv     = has_prv ? nxt - 1 : 0;
        if (has_prv && v <= span_hi[prv]) begin
            fresh_res.push_back(make_res(STS_COVERED, span_lo[prv], span_hi[prv], 1'b1));
            return;
        end
        // Widen to 17 bits so a span ending at the top never wraps.
        grow_up   = has_prv && ({1'b0, span_hi[prv]} + 17'd1 == {1'b0, v});
        grow_down = has_nxt && ({1'b0, span_lo[nxt]} - 17'd1 == {1'b0, v});
        if (grow_up && grow_down) begin
            // Join: the lower span swallows the upper one, close the gap.
            span_hi[prv] = span_hi[nxt];
            for (k = nxt; k + 1 < span_count; k++) begin
                span_lo[k] = span_lo[k + 1];
                span_hi[k] = span_hi[k + 1];
            end
            span_count--;
            fresh_res.push_back(make_res(STS_GROW, span_lo[prv], span_hi[prv], 1'b1));
        end else if (grow_up) begin
            span_hi[prv] = v;
            fresh_res.push_back(make_res(STS_GROW, span_lo[prv], span_hi[prv], 1'b1));
        end else if (grow_down) begin
            span_lo[nxt] = v;
            fresh_res.push_back(make_res(STS_GROW, span_lo[nxt], span_hi[nxt], 1'b1));
        end else if (span_count >= MAX_INTERVALS) begin
            fresh_res.push_back(make_res(STS_FULL, 16'h0000, 16'h0000, 1'b1));
        end else begin
            for (k = span_count; k > nxt; k--) begin
                span_lo[k] = span_lo[k - 1];
                span_hi[k] = span_hi[k - 1];
            end
            span_lo[nxt] = v;
            span_hi[nxt] = v;
            span_count++;
            fresh_res.push_back(make_res(STS_NEW, v, v, 1'b1));
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table. A typed row carries its one expected result; the
    // rest are checked against the model.
    // ------------------------------------------------------------------
    typedef struct {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_row;

    t_row plan [$];

    function automatic void plan_row(input t_cmd c, input logic [15:0] v);
        t_row r;
        r.stim.cmd   = c;
        r.stim.value = v;
        r.typed      = 1'b0;
        r.want       = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_typed(input t_cmd c, input logic [15:0] v, input t_status st,
                                       input logic [15:0] lo, input logic [15:0] hi,
                                       input logic [4:0] cnt);
        t_row r;
        r.stim.cmd            = c;
        r.stim.value          = v;
        r.typed               = 1'b1;
        r.want.status         = st;
        r.want.range_start    = lo;
        r.want.range_end      = hi;
        r.want.last           = 1'b1;
        r.want.interval_count = cnt;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        // Cap the log; the count keeps going.
        if (mismatches <= 100)
            $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Sample at the edge, before the block's own updates land.
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: status %0d start %0h",
                                          o_out.status, o_out.range_start));
            end else begin
                want = expected_q.pop_front();
                check_field("status", 16'(o_out.status), 16'(want.status));
                check_field("range_start", o_out.range_start, want.range_start);
                check_field("range_end", o_out.range_end, want.range_end);
                check_field("last", 16'(o_out.last), 16'(want.last));
                check_field("interval_count", 16'(o_out.interval_count),
                            16'(want.interval_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one transaction and hold it until accepted, then model it.
    // Valid stays high on exit so back-to-back items need no extra edge.
    task automatic send_txn(input t_in it, input bit typed, input t_out want);
        int unsigned k;
        i_in    <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        apply_to_set(it);
        if (typed) begin
            expected_q.push_back(want);
        end else begin
            for (k = 0; k < fresh_res.size(); k++)
                expected_q.push_back(fresh_res[k]);
        end
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        t_in         it;
        int unsigned k, idx, d;

        // Empty set, the two ends of the value range, a value below the first
        // span with no predecessor, and a repeat at the very top.
        plan_typed(CMD_READ, 16'hFFFF, STS_EMPTY,   16'h0000, 16'h0000, 5'd0);
        plan_typed(CMD_ADD,  16'hFFFF, STS_NEW,     16'hFFFF, 16'hFFFF, 5'd1);
        plan_typed(CMD_ADD,  16'h0000, STS_NEW,     16'h0000, 16'h0000, 5'd2);
        plan_typed(CMD_ADD,  16'hFFFF, STS_COVERED, 16'hFFFF, 16'hFFFF, 5'd2);
        // Grow the top span downwards, grow the bottom one upwards, then join.
        plan_row(CMD_ADD,  16'hFFFE);
        plan_row(CMD_ADD,  16'h0001);
        plan_row(CMD_ADD,  16'h0003);
        plan_row(CMD_ADD,  16'h0002);
        plan_row(CMD_READ, 16'h0000);
        // Alternating bit patterns, then fill the table.
        plan_row(CMD_ADD,  16'h5555);
        plan_row(CMD_ADD,  16'hAAAA);
        for (k = 1; k <= 12; k++)
            plan_row(CMD_ADD, 16'(k * 4096 + 8));
        // Full: a lone value is dropped, but growing a span still works.
        plan_typed(CMD_ADD,  16'h7777, STS_FULL,    16'h0000, 16'h0000, 5'd16);
        plan_row(CMD_ADD,  16'h0004);
        plan_row(CMD_READ, 16'h1234);

        // Hold reset, then release it at an edge.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < plan.size(); k++) begin
            send_txn(plan[k].stim, plan[k].typed, plan[k].want);
            sender_gap();
        end

        // Random part: mostly values at or near existing span edges so that
        // spans grow, join and refill; the rest are wild values and read-outs.
        for (k = 0; k < RANDOM_TXNS; k++) begin
            if (k == HOLD_OFF_AT)
                hold_off_now = 1'b1;
            if (k == DRAIN_PAUSE_AT) begin
                // Pause until every owed result has come back.
                i_valid <= 1'b0;
                do
                    @(posedge i_clk);
                while (expected_q.size() != 0);
            end
            if (k == RANDOM_TXNS - QUIET_TXNS)
                quiet = 1'b1;

            it.value = 16'($urandom);
            d        = $urandom_range(0, 99);
            if (d < 12) begin
                it.cmd = CMD_READ;
            end else begin
                it.cmd = CMD_ADD;
                if (d >= 25 && span_count != 0) begin
                    idx = $urandom_range(0, span_count - 1);
                    d   = $urandom_range(0, 3);
                    case ($urandom_range(0, 2))
                        0: it.value = span_lo[idx] - 16'(d + 1);
                        1: it.value = span_hi[idx] + 16'(d + 1);
                        default: it.value = span_lo[idx] +
                                 16'($urandom_range(0, span_hi[idx] - span_lo[idx]));
                    endcase
                end
            end
            send_txn(it, 1'b0, '0);
            sender_gap();
        end

        // Wait for every owed result, then allow time for any stray extras.
        i_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request, and
    // open stretches between them.
    // ------------------------------------------------------------------
    initial begin : receiver
        int unsigned run;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_now) begin
                // Hold off long enough for the block to back up into its input.
                hold_off_now = 1'b0;
                i_stall <= 1'b1;
                for (run = 0; run < HOLD_OFF_CYCLES; run++)
                    @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // Watchdog: end a hung run.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
